// File: rtl/psue_pkg.sv
// package for the particle swarm update engine
// types, register indexes, state encoding, size and fitness constants; no dependencies
`timescale 1ns / 1ps
package psue_pkg;

  localparam int PARTICLES  = 16;
  localparam int DIMENSIONS = 8;
  localparam int PW = $clog2(PARTICLES);
  localparam int DW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam int AW = PW + DW;
  localparam int DEPTH = PARTICLES * DIMENSIONS;
  localparam logic signed [31:0] FIT_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0, OP_FIT = 2'd1, OP_MOVE = 2'd2, OP_ROUND = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_INERTIA = 3'd0, REG_COGN = 3'd1, REG_SOCIAL = 3'd2, REG_FLOOR = 3'd3,
    REG_CEIL = 3'd4, REG_SPEED = 3'd5, REG_TOL = 3'd6, REG_STAG = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_RD2, ST_MUL, ST_COPY_RD, ST_COPY_WR, ST_FITG,
    ST_CLAMP, ST_WB, ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         particle_index;
    logic [2:0]         dimension_index;
    logic signed [15:0] position_in;
    logic signed [15:0] velocity_in;
    logic signed [31:0] fitness_in;
    logic [15:0]        random_one;
    logic [15:0]        random_two;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         particle_out;
    logic [2:0]         dimension_out;
    logic signed [15:0] position_out;
    logic signed [15:0] velocity_out;
    logic signed [31:0] global_fitness_out;
    logic [3:0]         global_holder;
    logic [15:0]        stagnation_out;
    logic               converged;
  } out_word_t;

endpackage

// File: rtl/psue_ram.sv
// generic single-port-write ram with one registered read port
// no dependencies
`timescale 1ns / 1ps
module psue_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/particle_swarm_update_engine.sv
// top level of the particle swarm update engine
// uses psue_pkg and psue_ram for the position, velocity and personal best stores
`timescale 1ns / 1ps
// A small sequencer serves one word at a time, and in_ready is high only in idle.
// Load and end round go from ST_RD to ST_OUT, fitness through ST_FITG, and
// move through ST_RD2, ST_MUL, ST_CLAMP and ST_WB. A fitness word that
// improves the personal best also runs ST_COPY_RD and ST_COPY_WR once per
// dimension, because each dimension of the position store is copied into
// the personal best store through its one port. A move does two store reads,
// then five products through one shared 33x33 signed multiplier, one product
// per cycle: w*v, c1*r1, c2*r2, then (c1*r1)*(pb-x) and (c2*r2)*(g-x). An
// accumulate follows, then round, clamp and write-back. in_ready comes back
// on the edge that raises out_valid.
// A result waits in an output register until out_ready. The next result can
// leave only once that one is taken.
// No clearing pass: the per-particle fitness table lives in flip-flops and
// resets at once.
module particle_swarm_update_engine
  import psue_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic [15:0] w_r, c1_r, c2_r, stag_lim_r;
  logic signed [15:0] floor_r, ceil_r;
  logic [14:0] speed_r;
  logic [30:0] tol_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= 16'd2867; c1_r <= 16'd6144; c2_r <= 16'd6144;
      floor_r <= -16'sd2560; ceil_r <= 16'sd2560; speed_r <= 15'd512;
      tol_r <= 31'd1; stag_lim_r <= 16'd50;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_INERTIA: w_r <= cfg_data[15:0];
        REG_COGN:    c1_r <= cfg_data[15:0];
        REG_SOCIAL:  c2_r <= cfg_data[15:0];
        REG_FLOOR:   floor_r <= cfg_data[15:0];
        REG_CEIL:    ceil_r <= cfg_data[15:0];
        REG_SPEED:   speed_r <= cfg_data[14:0];
        REG_TOL:     tol_r <= cfg_data[30:0];
        REG_STAG:    stag_lim_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // swarm state
  logic signed [31:0] pfit_r [PARTICLES];
  logic signed [31:0] gfit_r, round_fit_r;
  logic [PW-1:0] holder_r;
  logic [15:0] stag_r;

  // sequencer and datapath registers
  state_t state_r, state_nxt;
  in_word_t item_r;
  out_word_t out_r;
  logic out_valid_r;
  logic [2:0] step_r;              // product number in the move chain
  logic [DW:0] cnt_r;              // copy counter
  logic signed [15:0] x_r, pb_r, g_r;
  logic signed [63:0] acc_r;
  logic signed [32:0] ma_r, mb_r;  // shared multiplier operands
  logic signed [63:0] prod_r;
  logic signed [15:0] vel_r, pos_r;
  logic improve_r;

  // the one shared multiplier
  logic signed [65:0] mul_out;
  assign mul_out = ma_r * mb_r;

  // store ports
  logic pos_we, vel_we, pb_we;
  logic [AW-1:0] pos_wa, pb_wa, addr_k, pb_ra, pos_ra;
  logic [15:0] pos_wd, vel_wd, pb_wd, pos_rd, vel_rd, pb_rd;

  logic p_ok, d_ok;
  assign p_ok = ({28'd0, item_r.particle_index} < 32'(PARTICLES));
  assign d_ok = ({29'd0, item_r.dimension_index} < 32'(DIMENSIONS));
  assign addr_k = {item_r.particle_index[PW-1:0], item_r.dimension_index[DW-1:0]};

  psue_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_pos (
    .clk, .we(pos_we), .waddr(pos_wa), .wdata(pos_wd), .raddr(pos_ra), .rdata(pos_rd));
  psue_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_vel (
    .clk, .we(vel_we), .waddr(addr_k), .wdata(vel_wd), .raddr(addr_k), .rdata(vel_rd));
  psue_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_pb (
    .clk, .we(pb_we), .waddr(pb_wa), .wdata(pb_wd), .raddr(pb_ra), .rdata(pb_rd));

  op_t op;
  assign op = op_t'(item_r.opcode);
  logic g_valid;
  assign g_valid = (gfit_r != FIT_MAX);

  // rounding: nearest, ties up, from Q.36 to Q.8 is floor((s + 2^27) >> 28)
  logic signed [63:0] rsum;
  logic signed [35:0] vround;
  logic signed [35:0] vclamp, lim;
  logic signed [17:0] xsum, pclamp;
  assign rsum = acc_r + 64'sd134217728;
  assign vround = rsum[63:28];
  assign lim = 36'(speed_r);
  always_comb begin
    vclamp = vround;
    if (vclamp > lim) vclamp = lim;
    if (vclamp < -lim) vclamp = -lim;
  end
  assign xsum = 18'(x_r) + 18'(vel_r);
  always_comb begin
    pclamp = xsum;
    if (pclamp > 18'(ceil_r)) pclamp = 18'(ceil_r);
    if (pclamp < 18'(floor_r)) pclamp = 18'(floor_r);
  end

  // end-of-round difference
  logic signed [32:0] fdiff, fabs;
  assign fdiff = 33'(gfit_r) - 33'(round_fit_r);
  assign fabs = fdiff[32] ? -fdiff : fdiff;

  // next state and store control
  always_comb begin
    state_nxt = state_r;
    pos_we = 1'b0; vel_we = 1'b0; pb_we = 1'b0;
    pos_wa = addr_k; pb_wa = addr_k; pos_ra = addr_k; pb_ra = addr_k;
    pos_wd = item_r.position_in; vel_wd = item_r.velocity_in; pb_wd = item_r.position_in;
    case (state_r)
      ST_IDLE: if (in_valid && in_ready) state_nxt = ST_RD;
      ST_RD: begin
        case (op)
          OP_LOAD: begin
            pos_we = p_ok && d_ok; vel_we = p_ok && d_ok; pb_we = p_ok && d_ok;
            state_nxt = ST_OUT;
          end
          OP_MOVE: state_nxt = (p_ok && d_ok) ? ST_RD2 : ST_OUT;
          OP_FIT: state_nxt = ST_FITG;
          default: state_nxt = ST_OUT;
        endcase
      end
      ST_RD2: begin
        pb_ra = {holder_r, item_r.dimension_index[DW-1:0]};
        state_nxt = ST_MUL;
      end
      ST_MUL: if (step_r == 3'd5) state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_WB;
      ST_WB: begin
        pos_we = 1'b1; vel_we = 1'b1;
        pos_wd = pclamp[15:0]; vel_wd = vel_r;
        state_nxt = ST_OUT;
      end
      ST_FITG: state_nxt = improve_r ? ST_COPY_RD : ST_OUT;
      ST_COPY_RD: begin
        pos_ra = {item_r.particle_index[PW-1:0], cnt_r[DW-1:0]};
        state_nxt = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        pb_we = 1'b1;
        pb_wa = {item_r.particle_index[PW-1:0], cnt_r[DW-1:0]};
        pb_wd = pos_rd;
        state_nxt = (cnt_r == (DW+1)'(DIMENSIONS - 1)) ? ST_OUT : ST_COPY_RD;
      end
      ST_OUT: if (!out_valid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  logic signed [31:0] pfit_sel;
  assign pfit_sel = pfit_r[item_r.particle_index[PW-1:0]];
  logic signed [31:0] pfit_new;
  assign pfit_new = improve_r ? item_r.fitness_in : pfit_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PARTICLES; i++) pfit_r[i] <= FIT_MAX;
      gfit_r <= FIT_MAX; round_fit_r <= FIT_MAX;
      holder_r <= '0; stag_r <= '0;
      out_valid_r <= 1'b0; step_r <= '0; cnt_r <= '0; improve_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_valid) item_r <= in_data;
        ST_RD: begin
          step_r <= '0; cnt_r <= '0;
          vel_r <= '0; pos_r <= '0;
          if (op == OP_LOAD && p_ok && d_ok) begin
            pos_r <= item_r.position_in; vel_r <= item_r.velocity_in;
          end
          improve_r <= p_ok && (item_r.fitness_in < pfit_sel);
          if (op == OP_ROUND) begin
            if (fabs < 33'(tol_r)) begin
              if (stag_r != 16'hFFFF) stag_r <= stag_r + 16'd1;
            end else stag_r <= '0;
            round_fit_r <= gfit_r;
          end
        end
        ST_RD2: begin
          x_r <= pos_rd; pb_r <= pb_rd;
          ma_r <= {17'd0, w_r}; mb_r <= {{17{vel_rd[15]}}, vel_rd};
          acc_r <= '0;
        end
        ST_MUL: begin
          // shared multiplier: one product per cycle, each lands in prod_r
          prod_r <= mul_out[63:0];
          step_r <= step_r + 3'd1;
          case (step_r)
            3'd0: begin
              g_r <= g_valid ? pb_rd : 16'sd0;
              ma_r <= {17'd0, c1_r};
              mb_r <= {17'd0, item_r.random_one};
            end
            3'd1: begin
              acc_r <= prod_r <<< 16;
              ma_r <= {17'd0, c2_r};
              mb_r <= {17'd0, item_r.random_two};
            end
            3'd2: begin
              ma_r <= {1'b0, prod_r[31:0]};
              mb_r <= 33'(pb_r) - 33'(x_r);
            end
            3'd3: begin
              ma_r <= {1'b0, prod_r[31:0]};
              mb_r <= 33'(g_r) - 33'(x_r);
            end
            default: acc_r <= acc_r + prod_r;
          endcase
        end
        ST_CLAMP: begin
          vel_r <= vclamp[15:0];
        end
        ST_WB: pos_r <= pclamp[15:0];
        ST_FITG: begin
          if (p_ok) begin
            pfit_r[item_r.particle_index[PW-1:0]] <= pfit_new;
            if (pfit_new < gfit_r) begin
              gfit_r <= pfit_new; holder_r <= item_r.particle_index[PW-1:0];
            end
          end
        end
        ST_COPY_WR: cnt_r <= cnt_r + (DW+1)'(1);
        ST_OUT: if (!out_valid_r) out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // output word, registered once the sequencer reaches ST_OUT
  logic conv;
  assign conv = (33'(gfit_r) < $signed({2'b00, tol_r})) || (stag_r >= stag_lim_r);
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && !out_valid_r) begin
      out_r.particle_out <= item_r.particle_index;
      out_r.dimension_out <= item_r.dimension_index;
      out_r.position_out <= pos_r;
      out_r.velocity_out <= vel_r;
      out_r.global_fitness_out <= gfit_r;
      out_r.global_holder <= 4'(holder_r);
      out_r.stagnation_out <= stag_r;
      out_r.converged <= conv;
    end
  end

endmodule

// File: tb/sv/psue_checker.sv
// scoreboard for the particle swarm update engine: mirrors the particle table
// and global best, predicts one result word per input word; uses psue_pkg
`timescale 1ns / 1ps
module psue_checker
  import psue_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_word_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_word_t  out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  output int         errors,
  output int         pending
);

  logic [15:0] w_gain, c1_gain, c2_gain, stag_lim;
  logic signed [15:0] pos_lo, pos_hi;
  logic [14:0] vmax;
  logic [30:0] tol;

  logic signed [15:0] pos_mem [DEPTH];
  logic signed [15:0] vel_mem [DEPTH];
  logic signed [15:0] best_mem [DEPTH];
  logic signed [31:0] pfit [PARTICLES];
  logic signed [31:0] gfit, start_fit;
  logic [3:0] holder;
  logic [15:0] stag_cnt;

  out_word_t expected_q [$];

  task automatic report(input string what);
    $display("psue_checker: mismatch %s at %0t", what, $realtime);
    errors++;
  endtask

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  // one swarm step, updates the mirror and returns the word it yields
  function automatic out_word_t swarm_step(in_word_t w);
    out_word_t r;
    int k;
    longint x, v, pb, g, acc, vn, xn, diff;
    r = '0;
    k = w.particle_index * DIMENSIONS + w.dimension_index;
    case (op_t'(w.opcode))
      OP_LOAD: begin
        pos_mem[k] = w.position_in;
        vel_mem[k] = w.velocity_in;
        best_mem[k] = w.position_in;
        r.position_out = w.position_in;
        r.velocity_out = w.velocity_in;
      end
      OP_FIT: begin
        if (w.fitness_in < pfit[w.particle_index]) begin
          pfit[w.particle_index] = w.fitness_in;
          for (int i = 0; i < DIMENSIONS; i++)
            best_mem[w.particle_index * DIMENSIONS + i] =
              pos_mem[w.particle_index * DIMENSIONS + i];
        end
        if (pfit[w.particle_index] < gfit) begin
          gfit = pfit[w.particle_index];
          holder = w.particle_index;
        end
      end
      OP_MOVE: begin
        x = pos_mem[k];
        v = vel_mem[k];
        pb = best_mem[k];
        // no global best yet: pull toward zero
        g = (gfit != FIT_MAX) ? longint'(best_mem[holder * DIMENSIONS + w.dimension_index]) : 0;
        acc = longint'(w_gain) * v * 65536;
        acc += longint'(c1_gain) * longint'(w.random_one) * (pb - x);
        acc += longint'(c2_gain) * longint'(w.random_two) * (g - x);
        // round half up: floor of (acc + half)
        vn = (acc + (longint'(1) <<< 27)) >>> 28;
        vn = clip(vn, -longint'(vmax), longint'(vmax));
        xn = x + vn;
        if (xn > pos_hi) xn = pos_hi;
        if (xn < pos_lo) xn = pos_lo;  // crossed bounds: floor wins
        vel_mem[k] = vn[15:0];
        pos_mem[k] = xn[15:0];
        r.position_out = xn[15:0];
        r.velocity_out = vn[15:0];
      end
      OP_ROUND: begin
        diff = longint'(gfit) - longint'(start_fit);
        if (diff < 0) diff = -diff;
        if (diff < longint'(tol)) begin
          if (stag_cnt != 16'hFFFF) stag_cnt++;
        end else begin
          stag_cnt = '0;
        end
        start_fit = gfit;
      end
    endcase
    r.particle_out = w.particle_index;
    r.dimension_out = w.dimension_index;
    r.global_fitness_out = gfit;
    r.global_holder = holder;
    r.stagnation_out = stag_cnt;
    r.converged = (longint'(gfit) < longint'(tol)) || (stag_cnt >= stag_lim);
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      w_gain <= 16'd2867; c1_gain <= 16'd6144; c2_gain <= 16'd6144;
      pos_lo <= -16'sd2560; pos_hi <= 16'sd2560; vmax <= 15'd512;
      tol <= 31'd1; stag_lim <= 16'd50;
      for (int i = 0; i < PARTICLES; i++) pfit[i] = FIT_MAX;
      gfit = FIT_MAX; start_fit = FIT_MAX; holder = '0; stag_cnt = '0;
      errors = 0;
      expected_q.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_INERTIA: w_gain <= cfg_data[15:0];
          REG_COGN:    c1_gain <= cfg_data[15:0];
          REG_SOCIAL:  c2_gain <= cfg_data[15:0];
          REG_FLOOR:   pos_lo <= cfg_data[15:0];
          REG_CEIL:    pos_hi <= cfg_data[15:0];
          REG_SPEED:   vmax <= cfg_data[14:0];
          REG_TOL:     tol <= cfg_data[30:0];
          REG_STAG:    stag_lim <= cfg_data[15:0];
        endcase
      end
      if (in_valid && in_ready) expected_q = {expected_q, swarm_step(in_data)};
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected word");
        end else begin
          e = expected_q.pop_front();
          if (out_data.particle_out != e.particle_out) report("particle_out");
          if (out_data.dimension_out != e.dimension_out) report("dimension_out");
          if (out_data.position_out != e.position_out) report("position_out");
          if (out_data.velocity_out != e.velocity_out) report("velocity_out");
          if (out_data.global_fitness_out != e.global_fitness_out)
            report("global_fitness_out");
          if (out_data.global_holder != e.global_holder) report("global_holder");
          if (out_data.stagnation_out != e.stagnation_out) report("stagnation_out");
          if (out_data.converged != e.converged) report("converged");
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// stimulus and verdict for the particle swarm update engine
// depends on psue_pkg, particle_swarm_update_engine and psue_checker
`timescale 1ns / 1ps
module tb_top;
  import psue_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int errors, pending;
  int quiet_cycles = 0;
  bit calm = 1'b0;     // last part of the run: no idling at all
  bit timed_out = 1'b0;
  bit loaded [DEPTH];  // entries written so far, moves touch only these

  always #2 clk = ~clk;

  particle_swarm_update_engine uut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  psue_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  // result side: ready toggles in random bursts, always on once calm
  initial begin
    int burst;
    @(posedge clk iff rst_n);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        burst = $urandom_range(1, 19);
        out_ready <= $urandom_range(0, 2) != 0;
        repeat (burst) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no accepted word on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG && !timed_out) begin
      timed_out <= 1'b1;
      $display("tb_top: errors");
      $finish;
    end
  end

  // one word through the input channel, with an optional gap in front
  task automatic send_word(input in_word_t w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk iff in_ready);
    if (w.opcode == OP_LOAD) loaded[w.particle_index * DIMENSIONS + w.dimension_index] = 1'b1;
  endtask

  // one register write, with valid dropped before the next
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // back to idle between phases: all results back, then latency slack
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic in_word_t make_word(op_t op, int p, int d);
    in_word_t w;
    w.opcode = op;
    w.particle_index = 4'(p);
    w.dimension_index = 3'(d);
    w.position_in = 16'($urandom);
    w.velocity_in = 16'($urandom);
    w.fitness_in = $urandom;
    w.random_one = 16'($urandom);
    w.random_two = 16'($urandom);
    return w;
  endfunction

  // a move is legal only on a loaded entry
  function automatic bit move_ok(int p, int d);
    return loaded[p * DIMENSIONS + d];
  endfunction

  task automatic load_all(bit wide);
    in_word_t w;
    for (int p = 0; p < PARTICLES; p++)
      for (int d = 0; d < DIMENSIONS; d++) begin
        w = make_word(OP_LOAD, p, d);
        if (!wide) begin
          w.position_in = 16'($signed($urandom_range(0, 4000)) - 2000);
          w.velocity_in = 16'($signed($urandom_range(0, 600)) - 300);
        end
        send_word(w);
      end
  endtask

  // random swarm traffic: mostly rounds of fitness, moves and end of round
  task automatic swarm_phase(int count);
    in_word_t w;
    int p, d, sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      p = $urandom_range(0, PARTICLES - 1);
      d = $urandom_range(0, DIMENSIONS - 1);
      if (sel < 10) w = make_word(OP_LOAD, p, d);
      else if (sel < 35) begin
        w = make_word(OP_FIT, p, d);
        if ($urandom_range(0, 1)) w.fitness_in = $signed($urandom_range(0, 200000)) - 1000;
      end else if (sel < 85) w = make_word(OP_MOVE, p, d);
      else w = make_word(OP_ROUND, p, d);
      if (w.opcode == OP_MOVE && !move_ok(p, d)) w.opcode = OP_LOAD;
      send_word(w);
    end
  endtask

  initial begin
    in_word_t w;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: moves with no global best, extremes, ties and stagnation
    load_all(1'b1);
    w = make_word(OP_MOVE, 0, 0); w.random_one = '0; w.random_two = 16'hFFFF; send_word(w);
    w = make_word(OP_ROUND, 15, 7); send_word(w);
    w = make_word(OP_FIT, 3, 0); w.fitness_in = 32'sh7FFF_FFFF; send_word(w);
    w = make_word(OP_FIT, 3, 0); w.fitness_in = 32'sh8000_0000; send_word(w);
    w = make_word(OP_FIT, 4, 0); w.fitness_in = 32'sh8000_0000; send_word(w);
    w = make_word(OP_MOVE, 15, 7); w.random_one = 16'hFFFF; send_word(w);
    w = make_word(OP_MOVE, 3, 5); send_word(w);
    w = make_word(OP_ROUND, 0, 0); send_word(w);
    w = make_word(OP_ROUND, 0, 0); send_word(w);
    w = make_word(OP_LOAD, 9, 2); w.position_in = 16'sh7FFF; w.velocity_in = 16'sh8000;
    send_word(w);
    w = make_word(OP_MOVE, 9, 2); send_word(w);
    drain();

    // extreme gains, crossed bounds, zero limits
    write_reg(REG_INERTIA, 32'hFFFF);
    write_reg(REG_COGN, 32'hFFFF);
    write_reg(REG_SOCIAL, 32'hFFFF);
    write_reg(REG_FLOOR, 32'h0000_7FFF);
    write_reg(REG_CEIL, 32'hFFFF_8000);
    write_reg(REG_SPEED, 32'h7FFF);
    write_reg(REG_TOL, 32'h7FFF_FFFF);
    write_reg(REG_STAG, 32'h0);
    swarm_phase(150);
    drain();

    write_reg(REG_INERTIA, 32'h0);
    write_reg(REG_COGN, 32'h0);
    write_reg(REG_SOCIAL, 32'h0);
    write_reg(REG_FLOOR, 32'hFFFF_8000);
    write_reg(REG_CEIL, 32'h7FFF);
    write_reg(REG_SPEED, 32'h0);
    write_reg(REG_TOL, 32'h0);
    write_reg(REG_STAG, 32'hFFFF);
    swarm_phase(150);
    drain();

    // typical settings with random content
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_INERTIA, $urandom_range(0, 8000));
      write_reg(REG_COGN, $urandom);
      write_reg(REG_SOCIAL, $urandom_range(0, 12000));
      write_reg(REG_FLOOR, -$urandom_range(0, 6000));
      write_reg(REG_CEIL, $urandom_range(0, 6000));
      write_reg(REG_SPEED, $urandom);
      write_reg(REG_TOL, $urandom_range(0, 70000));
      write_reg(REG_STAG, $urandom_range(0, 6));
      if (ph == 0) load_all(1'b0);
      if (ph == 3) calm = 1'b1;
      swarm_phase(180);
      drain();
    end

    drain();
    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
